// File: src/pfs_pkg.sv
// Shared constants and types of the Phong face shader.
// No dependencies; imported by the interfaces' users, the normaliser and the top level.
`default_nettype none
package pfs_pkg;

  // Fixed-point formats of unit vectors and lighting terms
  localparam int UNIT_FRAC    = 14;
  localparam int UNIT_W       = 16;
  localparam int MAG_W        = 17;
  localparam int NORM_LIMIT   = 17;
  localparam int SUMSQ_W      = 36;
  localparam int ACC_W        = 68;
  localparam int SEARCH_STEPS = UNIT_FRAC + 1;
  localparam int NORM_LAT     = 3 + SEARCH_STEPS;

  localparam int FRAC16_W     = 17;
  localparam int K_030        = 19661;
  localparam int K_055        = 36045;
  localparam int K_SPEC_COL   = 19661 * 255;
  localparam int K_ONE16      = 65536;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MODEL_OFFSET = 2'd0,
    CFG_VIEW_X       = 2'd1,
    CFG_VIEW_Y       = 2'd2,
    CFG_VIEW_Z       = 2'd3
  } cfg_idx_t;

  // Per-face data that rides alongside the arithmetic
  typedef struct packed {
    logic [7:0] color_r;
    logic [7:0] color_g;
    logic [7:0] color_b;
    logic       last;
  } side_t;

endpackage
`default_nettype wire

// File: src/pfs_if.sv
// Handshake channels of the Phong face shader: face input and shade output.
// Stand-alone; the face channel's coordinate widths follow COORD_WIDTH.
`default_nettype none
interface pfs_face_if #(parameter int COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic signed [COORD_WIDTH-1:0] normal_x;
  logic signed [COORD_WIDTH-1:0] normal_y;
  logic signed [COORD_WIDTH-1:0] normal_z;
  logic [7:0]                    color_r;
  logic [7:0]                    color_g;
  logic [7:0]                    color_b;
  logic                          last_item;

  modport source (output valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                  color_r, color_g, color_b, last_item, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                color_r, color_g, color_b, last_item, output ready);
endinterface

interface pfs_shade_if;
  logic       valid;
  logic       ready;
  logic [7:0] shade_r;
  logic [7:0] shade_g;
  logic [7:0] shade_b;
  logic       last_out;

  modport source (output valid, shade_r, shade_g, shade_b, last_out, input ready);
  modport sink (input valid, shade_r, shade_g, shade_b, last_out, output ready);
endinterface
`default_nettype wire

// File: src/pfs_normalize.sv
// Pipelined exact normaliser of one 3-vector to Q1.14 unit components.
// Depends on pfs_pkg; every stage advances only while en is high.
`default_nettype none
module pfs_normalize
  import pfs_pkg::*;
#(
  parameter int VEC_WIDTH = 18
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [VEC_WIDTH-1:0] vec  [3],
  output logic signed [UNIT_W-1:0]    uvec [3]
);

  localparam int XW  = (VEC_WIDTH > NORM_LIMIT) ? VEC_WIDTH : NORM_LIMIT + 1;
  localparam int SHW = $clog2(XW);
  localparam int QW  = UNIT_FRAC + 1;

  logic [XW-1:0]  magx [3];
  logic [XW-1:0]  orv;
  logic [SHW-1:0] sh;

  logic [MAG_W-1:0]   m1   [3];
  logic               neg1 [3];
  logic [2*MAG_W-1:0] sq2  [3];
  logic               neg2 [3];

  logic [SUMSQ_W-1:0] s_r   [SEARCH_STEPS+1];
  logic [ACC_W-1:0]   rhs_r [SEARCH_STEPS+1][3];
  logic [ACC_W-1:0]   p_r   [SEARCH_STEPS+1][3];
  logic [ACC_W-1:0]   qs_r  [SEARCH_STEPS+1][3];
  logic [QW-1:0]      q_r   [SEARCH_STEPS+1][3];
  logic               neg_r [SEARCH_STEPS+1][3];

  // Magnitudes and the common right shift that brings them below the limit
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      magx[i] = XW'(unsigned'(vec[i][VEC_WIDTH-1] ? -vec[i] : vec[i]));
    end
    orv = magx[0] | magx[1] | magx[2];
    sh  = '0;
    for (int b = NORM_LIMIT; b < XW; b++) begin
      if (orv[b]) sh = SHW'(b - NORM_LIMIT + 1);
    end
  end

  // Scale magnitudes, square, then form the sum of squares and the bounds
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1[i]          <= MAG_W'(magx[i] >> sh);
        neg1[i]        <= vec[i][VEC_WIDTH-1];
        sq2[i]         <= (2*MAG_W)'(m1[i]) * (2*MAG_W)'(m1[i]);
        neg2[i]        <= neg1[i];
        rhs_r[0][i]    <= ACC_W'(sq2[i]) << (2 * UNIT_FRAC);
        neg_r[0][i]    <= neg2[i];
        p_r[0][i]      <= '0;
        qs_r[0][i]     <= '0;
        q_r[0][i]      <= '0;
      end
      s_r[0] <= SUMSQ_W'(sq2[0]) + SUMSQ_W'(sq2[1]) + SUMSQ_W'(sq2[2]);
    end
  end

  // One quotient bit per stage: keep q*q*s and q*s so each trial is shifts and adds
  for (genvar k = 1; k <= SEARCH_STEPS; k++) begin : g_step
    localparam int B = SEARCH_STEPS - k;
    logic [ACC_W-1:0] tp [3];
    logic [ACC_W-1:0] tq [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        tq[i] = qs_r[k-1][i] + (ACC_W'(s_r[k-1]) << B);
        tp[i] = p_r[k-1][i] + (qs_r[k-1][i] << (B + 1)) + (ACC_W'(s_r[k-1]) << (2 * B));
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k] <= s_r[k-1];
        for (int i = 0; i < 3; i++) begin
          rhs_r[k][i] <= rhs_r[k-1][i];
          neg_r[k][i] <= neg_r[k-1][i];
          if (tp[i] <= rhs_r[k-1][i]) begin
            q_r[k][i]  <= q_r[k-1][i] | (QW'(1) << B);
            p_r[k][i]  <= tp[i];
            qs_r[k][i] <= tq[i];
          end else begin
            q_r[k][i]  <= q_r[k-1][i];
            p_r[k][i]  <= p_r[k-1][i];
            qs_r[k][i] <= qs_r[k-1][i];
          end
        end
      end
    end
  end

  // Apply signs; a zero vector gives the zero vector
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s_r[SEARCH_STEPS] == '0) begin
        uvec[i] = '0;
      end else if (neg_r[SEARCH_STEPS][i]) begin
        uvec[i] = -signed'(UNIT_W'(q_r[SEARCH_STEPS][i]));
      end else begin
        uvec[i] = signed'(UNIT_W'(q_r[SEARCH_STEPS][i]));
      end
    end
  end

endmodule
`default_nettype wire

// File: src/phong_face_shader_unit.sv
// Top level of the Phong face shader: config registers, light and normal
// normalisers, dot products, specular power chain and colour mix.
// Depends on pfs_pkg, pfs_if (pfs_face_if, pfs_shade_if) and pfs_normalize.
//
//  channel  | dir | payload                                       | handshake
//  face     | in  | pos_x/y/z, normal_x/y/z, color_r/g/b, last_item | valid/ready
//  shade    | out | shade_r/g/b, last_out                         | valid/ready
//  cfg      | in  | cfg_index, cfg_data                           | cfg_we, no wait
//
// One face per cycle unless a waiting result stalls the pipeline; the depth is set by the
// 15-step bitwise normaliser search and one multiply stage per specular power.
// Reset clears the valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline in place; face.ready follows it.
`default_nettype none
module phong_face_shader_unit
  import pfs_pkg::*;
#(
  parameter int COORD_WIDTH   = 16,
  parameter int SPEC_EXPONENT = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  pfs_face_if.sink               face,
  pfs_shade_if.source            shade,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data
);

  localparam int MW      = COORD_WIDTH + 2;
  localparam int PW      = 2 * COORD_WIDTH + 2;
  localparam int S_UNIT  = 1 + NORM_LAT;
  localparam int S_PROD  = S_UNIT + 1;
  localparam int S_SUM   = S_UNIT + 2;
  localparam int S_SQ    = S_UNIT + 3;
  localparam int S_C16   = S_UNIT + 4;
  localparam int S_SPEC  = S_C16 + SPEC_EXPONENT;
  localparam int S_MUL   = S_SPEC + 1;
  localparam int DEPTH   = S_MUL + 1;
  localparam logic signed [PW-1:0] FLIP_THR = PW'(1) << (2 * (COORD_WIDTH - 2));

  logic adv;

  logic signed [COORD_WIDTH-1:0] model_offset;
  logic signed [COORD_WIDTH-1:0] view [3];

  logic [DEPTH:1] vld;
  side_t          side_r [DEPTH+1];
  logic           flp_r  [S_UNIT+1];

  logic signed [MW-1:0] lraw [3];
  logic signed [MW-1:0] nraw [3];
  logic signed [MW-1:0] nsum;
  logic signed [PW-1:0] prod;

  logic signed [UNIT_W-1:0] lu [3];
  logic signed [UNIT_W-1:0] nu [3];

  logic signed [2*UNIT_W-1:0] ln_r [3];
  logic signed [2*UNIT_W-1:0] ll_p [3];
  logic signed [31:0]         d_r;
  logic [31:0]                ll_r;
  logic signed [63:0]         dsq_r;
  logic [31:0]                llq_r;
  logic [33:0]                dm_r;
  logic signed [31:0]         negd;
  logic signed [65:0]         c56;
  logic [25:0]                c_sh;

  logic [FRAC16_W-1:0] spec_r [SPEC_EXPONENT+1];
  logic [FRAC16_W-1:0] c16_r  [SPEC_EXPONENT+1];
  logic [FRAC16_W-1:0] diff_r [SPEC_EXPONENT+1];

  logic [24:0] cd_r [3];
  logic [39:0] sk_r;
  logic [47:0] tot  [3];
  logic [7:0]  sat  [3];
  logic [7:0]  shade_q [3];

  // Whole pipeline moves unless a result waits untaken
  assign adv        = !vld[DEPTH] || shade.ready;
  assign face.ready = adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      model_offset <= -(COORD_WIDTH'(1) << (COORD_WIDTH - 3));
      view[0]      <= COORD_WIDTH'(3) << (COORD_WIDTH - 3);
      view[1]      <= '0;
      view[2]      <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODEL_OFFSET: model_offset <= cfg_data;
        CFG_VIEW_X:       view[0]      <= cfg_data;
        CFG_VIEW_Y:       view[1]      <= cfg_data;
        CFG_VIEW_Z:       view[2]      <= cfg_data;
        default:          model_offset <= model_offset;
      endcase
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-1:1], face.valid};
    end
  end

  // Colour and end marker ride along the whole pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[1] <= '{color_r: face.color_r, color_g: face.color_g,
                     color_b: face.color_b, last: face.last_item};
      for (int j = 2; j <= DEPTH; j++) side_r[j] <= side_r[j-1];
    end
  end

  // Offset position relative to the viewer, extend the normal, sum its components
  always_ff @(posedge clk) begin
    if (adv) begin
      lraw[0] <= MW'(face.pos_x) + MW'(model_offset) - MW'(view[0]);
      lraw[1] <= MW'(face.pos_y) + MW'(model_offset) - MW'(view[1]);
      lraw[2] <= MW'(face.pos_z) + MW'(model_offset) - MW'(view[2]);
      nraw[0] <= MW'(face.normal_x);
      nraw[1] <= MW'(face.normal_y);
      nraw[2] <= MW'(face.normal_z);
      nsum    <= MW'(face.normal_x) + MW'(face.normal_y) + MW'(face.normal_z);
    end
  end

  // Compare the homogeneous divisor with FLIP_THR, then hold the flag until the unit vectors arrive
  always_ff @(posedge clk) begin
    if (adv) begin
      prod     <= PW'(model_offset) * PW'(nsum);
      flp_r[3] <= prod > FLIP_THR;
      for (int j = 4; j <= S_UNIT; j++) flp_r[j] <= flp_r[j-1];
    end
  end

  pfs_normalize #(.VEC_WIDTH(MW)) u_norm_l (
    .clk  (clk),
    .en   (adv),
    .vec  (lraw),
    .uvec (lu)
  );

  pfs_normalize #(.VEC_WIDTH(MW)) u_norm_n (
    .clk  (clk),
    .en   (adv),
    .vec  (nraw),
    .uvec (nu)
  );

  // Component products, dot sums, squares, the diffuse multiply and the reflection term
  always_comb begin
    negd = -d_r;
    c56  = (66'(dsq_r) <<< 1) - (66'(llq_r) <<< 28);
    c_sh = c56[65:40];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ln_r[i] <= (flp_r[S_UNIT] ? -(2*UNIT_W)'(nu[i]) : (2*UNIT_W)'(nu[i]))
                   * (2*UNIT_W)'(lu[i]);
        ll_p[i] <= (2*UNIT_W)'(lu[i]) * (2*UNIT_W)'(lu[i]);
      end
      d_r   <= ln_r[0] + ln_r[1] + ln_r[2];
      ll_r  <= unsigned'(ll_p[0] + ll_p[1] + ll_p[2]);
      dsq_r <= 64'(d_r) * 64'(d_r);
      llq_r <= ll_r;
      if (d_r < 0) begin
        dm_r <= 34'(unsigned'(negd) >> 12) * 34'(K_030);
      end else begin
        dm_r <= '0;
      end
      // clamp the reflection term to [0, 1.0]
      if (c56 <= 0) begin
        c16_r[0] <= '0;
      end else if (c_sh > 26'(K_ONE16)) begin
        c16_r[0] <= FRAC16_W'(K_ONE16);
      end else begin
        c16_r[0] <= FRAC16_W'(c_sh);
      end
      diff_r[0] <= FRAC16_W'(dm_r >> 16) + FRAC16_W'(K_055);
      spec_r[0] <= FRAC16_W'(K_ONE16);
    end
  end

  // Specular power: one truncating multiply per stage
  for (genvar k = 1; k <= SPEC_EXPONENT; k++) begin : g_spec
    always_ff @(posedge clk) begin
      if (adv) begin
        spec_r[k] <= FRAC16_W'(((2*FRAC16_W)'(spec_r[k-1]) * (2*FRAC16_W)'(c16_r[k-1])) >> 16);
        c16_r[k]  <= c16_r[k-1];
        diff_r[k] <= diff_r[k-1];
      end
    end
  end

  // Colour mix and saturation
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tot[i] = (48'(cd_r[i]) << 16) + 48'(sk_r);
      sat[i] = (tot[i][47:32] > 16'd255) ? 8'd255 : tot[i][39:32];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cd_r[0]    <= 25'(side_r[S_SPEC].color_r) * 25'(diff_r[SPEC_EXPONENT]);
      cd_r[1]    <= 25'(side_r[S_SPEC].color_g) * 25'(diff_r[SPEC_EXPONENT]);
      cd_r[2]    <= 25'(side_r[S_SPEC].color_b) * 25'(diff_r[SPEC_EXPONENT]);
      sk_r       <= 40'(spec_r[SPEC_EXPONENT]) * 40'(K_SPEC_COL);
      shade_q[0] <= sat[0];
      shade_q[1] <= sat[1];
      shade_q[2] <= sat[2];
    end
  end

  assign shade.valid    = vld[DEPTH];
  assign shade.shade_r  = shade_q[0];
  assign shade.shade_g  = shade_q[1];
  assign shade.shade_b  = shade_q[2];
  assign shade.last_out = side_r[DEPTH].last;

endmodule
`default_nettype wire
